FILE: sv/cp2u8_pkg.sv
// shared types and constants for the code point to utf-8 encoder
// no dependencies; imported by the front end, back end and top level
package cp2u8_pkg;

    localparam int unsigned FIELD_WIDTH = 20;
    localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = '1;

    // code point class limits
    localparam logic [31:0] CP_LIMIT1 = 32'h0000_0080;
    localparam logic [31:0] CP_LIMIT2 = 32'h0000_0800;
    localparam logic [31:0] CP_LIMIT3 = 32'h0001_0000;
    localparam logic [31:0] CP_LIMIT4 = 32'h0020_0000;

    // lead and continuation prefixes
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_TOO_SMALL = 2'd2
    } status_t;

    // config register index, taken from paddr bit 2
    typedef enum logic [0:0] {
        REG_CAPACITY  = 1'b0,
        REG_WRITE_EN  = 1'b1
    } reg_index_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [31:0] bytes;      // byte k in bits 8k+7:8k
        logic [1:0]  last_idx;   // byte count minus one
        logic        stored;
        logic        eos;
        logic        wr_en;
        logic        term_fail;  // terminator does not fit
        logic        oversize;
    } desc_t;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic [FIELD_WIDTH-1:0] byte_offset;
        logic                   byte_stored;
        logic                   run_last;
        logic                   string_done;
        status_t                status;
        logic [FIELD_WIDTH-1:0] total_size;
    } result_t;

endpackage

FILE: sv/cp2u8_front.sv
// front end: accepts code points, keeps the string byte count and discard flag
// and classifies each item into a descriptor; uses cp2u8_pkg
module cp2u8_front #(
    parameter int unsigned COUNT_WIDTH = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [31:0]                    code_point,
    input  logic                           end_of_string,
    input  logic [cp2u8_pkg::FIELD_WIDTH-1:0] capacity,
    input  logic                           write_enable,
    output logic                           push,
    input  logic                           q_ready,
    output cp2u8_pkg::desc_t               desc,
    output logic [COUNT_WIDTH-1:0]         base
);
    import cp2u8_pkg::*;

    localparam int unsigned EW = ((COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH) + 1;

    logic [COUNT_WIDTH-1:0] size_count_reg, size_count_next;
    logic                   discarding_reg, discarding_next;
    logic                   accept;
    logic                   oversize;
    logic [1:0]             last_idx;
    logic [31:0]            bytes;
    logic [COUNT_WIDTH:0]   sum_raw;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [EW-1:0]          fit_sum;

    assign in_ready = q_ready;
    assign accept   = in_valid & in_ready;
    assign oversize = code_point >= CP_LIMIT4;

    always_comb begin
        bytes    = '0;
        last_idx = 2'd0;
        if (code_point < CP_LIMIT1) begin
            bytes[7:0] = code_point[7:0];
        end else if (code_point < CP_LIMIT2) begin
            last_idx    = 2'd1;
            bytes[7:0]  = LEAD2 | {3'b000, code_point[10:6]};
            bytes[15:8] = CONT | (code_point[7:0] & CONT_MASK);
        end else if (code_point < CP_LIMIT3) begin
            last_idx     = 2'd2;
            bytes[7:0]   = LEAD3 | {4'b0000, code_point[15:12]};
            bytes[15:8]  = CONT | (code_point[13:6] & CONT_MASK);
            bytes[23:16] = CONT | (code_point[7:0] & CONT_MASK);
        end else begin
            last_idx     = 2'd3;
            bytes[7:0]   = LEAD4 | {5'b00000, code_point[20:18]};
            bytes[15:8]  = CONT | (code_point[19:12] & CONT_MASK);
            bytes[23:16] = CONT | (code_point[13:6] & CONT_MASK);
            bytes[31:24] = CONT | (code_point[7:0] & CONT_MASK);
        end
    end

    // saturating count after this item's bytes
    always_comb begin
        sum_raw   = {1'b0, size_count_reg} + (COUNT_WIDTH+1)'({1'b0, last_idx} + 3'd1);
        new_count = sum_raw[COUNT_WIDTH] ? '1 : sum_raw[COUNT_WIDTH-1:0];
        fit_sum   = EW'(size_count_reg) + EW'({1'b0, last_idx} + 3'd1);
    end

    always_comb begin
        desc.bytes     = bytes;
        desc.last_idx  = last_idx;
        desc.stored    = write_enable && (fit_sum <= EW'(capacity));
        desc.eos       = end_of_string;
        desc.wr_en     = write_enable;
        desc.term_fail = EW'(new_count) >= EW'(capacity);
        desc.oversize  = oversize;
        base           = size_count_reg;
        push           = accept & ~discarding_reg;
    end

    always_comb begin
        size_count_next = size_count_reg;
        discarding_next = discarding_reg;
        if (accept) begin
            priority if (discarding_reg) begin
                if (end_of_string) begin
                    discarding_next = 1'b0;
                    size_count_next = '0;
                end
            end else if (oversize) begin
                if (end_of_string) begin
                    size_count_next = '0;
                end else begin
                    discarding_next = 1'b1;
                end
            end else begin
                size_count_next = end_of_string ? '0 : new_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_count_reg <= '0;
            discarding_reg <= 1'b0;
        end else begin
            size_count_reg <= size_count_next;
            discarding_reg <= discarding_next;
        end
    end

endmodule

FILE: sv/cp2u8_queue.sv
// two-entry queue that decouples the front end from the byte emitter
// no package dependencies
module cp2u8_queue #(
    parameter int unsigned DATA_WIDTH = 60
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] out_data
);
    logic [DATA_WIDTH-1:0] data_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  do_push, do_pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = data_reg[rd_ptr_reg];
    assign do_push   = in_valid & in_ready;
    assign do_pop    = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: sv/cp2u8_back.sv
// back end: walks the head descriptor one result per cycle into an output register
// while res_ready is high or that register is empty; uses cp2u8_pkg
module cp2u8_back #(
    parameter int unsigned COUNT_WIDTH = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_pop,
    input  cp2u8_pkg::desc_t        desc,
    input  logic [COUNT_WIDTH-1:0]  base,
    output logic                    res_valid,
    input  logic                    res_ready,
    output cp2u8_pkg::result_t      res
);
    import cp2u8_pkg::*;

    localparam int unsigned EW = ((COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH) + 1;

    logic [2:0]             idx_reg, idx_next;
    logic [COUNT_WIDTH-1:0] off_reg, off_next;
    logic                   valid_reg, valid_next;
    result_t                res_reg, res_next;
    logic                   load_en, fire;
    logic [COUNT_WIDTH-1:0] cur_off, inc_off;
    logic [COUNT_WIDTH:0]   inc_raw;
    logic                   term, is_byte, is_last_byte, final_res;
    logic [FIELD_WIDTH-1:0] cur_clamp, inc_clamp;
    logic [EW-1:0]          cur_ext, inc_ext;

    assign load_en = ~valid_reg | res_ready;
    assign fire    = q_valid & load_en;

    always_comb begin
        cur_off      = (idx_reg == 3'd0) ? base : off_reg;
        inc_raw      = {1'b0, cur_off} + (COUNT_WIDTH+1)'(1);
        inc_off      = inc_raw[COUNT_WIDTH] ? '1 : inc_raw[COUNT_WIDTH-1:0];
        cur_ext      = EW'(cur_off);
        inc_ext      = EW'(inc_off);
        cur_clamp    = (cur_ext > EW'(FIELD_MAX)) ? FIELD_MAX : cur_ext[FIELD_WIDTH-1:0];
        inc_clamp    = (inc_ext > EW'(FIELD_MAX)) ? FIELD_MAX : inc_ext[FIELD_WIDTH-1:0];
        term         = desc.eos & desc.wr_en;
        is_byte      = ~desc.oversize & ~idx_reg[2] & (idx_reg[1:0] <= desc.last_idx);
        is_last_byte = is_byte & (idx_reg[1:0] == desc.last_idx);
        final_res    = desc.oversize | (is_last_byte & ~term) | ~is_byte;
    end

    always_comb begin
        res_next.out_byte    = 8'd0;
        res_next.byte_offset = cur_clamp;
        res_next.byte_stored = 1'b0;
        res_next.run_last    = 1'b1;
        res_next.string_done = 1'b1;
        res_next.status      = ST_OK;
        res_next.total_size  = cur_clamp;
        priority if (desc.oversize) begin
            res_next.status = ST_TOO_LARGE;
        end else if (is_byte) begin
            res_next.out_byte    = desc.bytes[{idx_reg[1:0], 3'b000} +: 8];
            res_next.byte_stored = desc.stored;
            res_next.run_last    = is_last_byte & ~term;
            res_next.string_done = is_last_byte & desc.eos & ~desc.wr_en;
            res_next.total_size  = inc_clamp;
        end else begin
            // terminator or capacity error
            res_next.byte_stored = ~desc.term_fail;
            res_next.status      = desc.term_fail ? ST_TOO_SMALL : ST_OK;
        end
    end

    always_comb begin
        idx_next   = idx_reg;
        off_next   = off_reg;
        valid_next = valid_reg;
        q_pop      = 1'b0;
        if (load_en) begin
            valid_next = q_valid;
        end
        if (fire) begin
            off_next = is_byte ? inc_off : cur_off;
            if (final_res) begin
                idx_next = 3'd0;
                q_pop    = 1'b1;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg <= off_next;
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

FILE: sv/code_point_to_utf8_encoder.sv
// top level of the code point to utf-8 encoder: config registers, front end,
// descriptor queue and byte emitter; uses cp2u8_pkg and the cp2u8_* modules
//
// One code point enters per request on the s_ side and leaves as its utf-8
// bytes, one result per cycle on the m_ side while m_tready is high, each with
// its buffer offset and running size. A code point gives 1 to 4 byte results,
// plus one terminator or capacity-error result on an end_of_string item when
// write_enable is set; an oversized code point gives one error result, and
// items skipped after it give none. The input side takes one request per cycle
// while the two-entry queue between the front end and the byte emitter has
// room, so the sustained rate is set by the one-byte result channel.
// capacity and write_enable are written over the apb-style port; the user must
// write them only while idle, as the block itself does not enforce it.
module code_point_to_utf8_encoder #(
    parameter int unsigned COUNT_WIDTH = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] code_point
    input  logic        s_tlast,   // end_of_string
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [27:8] byte_offset, [47:28] total_size
    output logic        m_tlast,   // run_last
    output logic [3:0]  m_tuser,   // [0] byte_stored, [1] string_done, [3:2] status
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cp2u8_pkg::*;

    localparam int unsigned QW = $bits(desc_t) + COUNT_WIDTH;

    logic [FIELD_WIDTH-1:0] capacity_reg, capacity_next;
    logic                   write_en_reg, write_en_next;
    logic                   cfg_write;
    reg_index_t             cfg_sel;

    logic                   push, q_in_ready, q_out_valid, q_pop;
    desc_t                  front_desc, back_desc;
    logic [COUNT_WIDTH-1:0] front_base, back_base;
    logic [QW-1:0]          q_in_data, q_out_data;
    result_t                res;

    // config registers; the word address picks the register, byte lanes ignored
    assign pready    = 1'b1;
    assign cfg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        capacity_next = capacity_reg;
        write_en_next = write_en_reg;
        if (cfg_write) begin
            unique case (cfg_sel)
                REG_CAPACITY: capacity_next = pwdata[FIELD_WIDTH-1:0];
                REG_WRITE_EN: write_en_next = pwdata[0];
                default:      capacity_next = capacity_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_CAPACITY: prdata = 32'(capacity_reg);
            REG_WRITE_EN: prdata = 32'(write_en_reg);
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
            write_en_reg <= 1'b1;
        end else begin
            capacity_reg <= capacity_next;
            write_en_reg <= write_en_next;
        end
    end

    // front end: classify and count
    cp2u8_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .code_point    (s_tdata),
        .end_of_string (s_tlast),
        .capacity      (capacity_reg),
        .write_enable  (write_en_reg),
        .push          (push),
        .q_ready       (q_in_ready),
        .desc          (front_desc),
        .base          (front_base)
    );

    // descriptor queue, base offset in the upper bits
    assign q_in_data = {front_base, front_desc};

    cp2u8_queue #(
        .DATA_WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_pop),
        .out_data  (q_out_data)
    );

    assign back_desc = desc_t'(q_out_data[$bits(desc_t)-1:0]);
    assign back_base = q_out_data[QW-1:$bits(desc_t)];

    // back end: one result per cycle into the output register while m_tready is high
    cp2u8_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_out_valid),
        .q_pop     (q_pop),
        .desc      (back_desc),
        .base      (back_base),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result packing
    assign m_tdata = {res.total_size, res.byte_offset, res.out_byte};
    assign m_tlast = res.run_last;
    assign m_tuser = {res.status, res.string_done, res.byte_stored};

endmodule

FILE: test/tb_code_point_to_utf8_encoder.sv
// self-checking testbench for code_point_to_utf8_encoder: directed table, then random strings
// under several idle and stall patterns; needs cp2u8_pkg and the encoder rtl, nothing else
`timescale 1ns / 1ps

module tb_code_point_to_utf8_encoder;
    import cp2u8_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned DRAIN_CYCLES   = 16;   // covers the front end and the two-entry queue
    localparam int unsigned HOLD_CYCLES    = 300;  // long receiver hold-off
    localparam int unsigned PHASE_ITEMS    = 46;

    // directed table row: a request or a register write
    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef struct {
        row_kind_t   kind;
        logic [31:0] value;     // code point, or register value
        logic        eos;
        reg_index_t  reg_sel;
        bit          typed;     // expectation written out in the table
        result_t     want;
    } stim_row_t;

    // dut ports
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // sideband that travels with the offered request
    bit          side_typed;
    result_t     side_want;

    // encoder model: config copy and string state
    logic [FIELD_WIDTH-1:0] cap_model  = '0;
    logic                   wen_model  = 1'b1;
    logic [FIELD_WIDTH-1:0] byte_count = '0;
    logic                   skipping   = 1'b0;

    result_t     pending_bytes[$];
    stim_row_t   directed_rows[$];

    int unsigned error_count    = 0;
    int unsigned requests_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned strings_sent   = 0;
    int unsigned reg_writes     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;

    // hold-off handshake between the stimulus and the receiver
    bit          hold_tgl  = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    code_point_to_utf8_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // global timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_bytes.size());
            $display("FAIL code_point_to_utf8_encoder");
            $finish;
        end
    end

    // saturating add on the byte counter
    function automatic logic [FIELD_WIDTH-1:0] count_plus(input logic [FIELD_WIDTH-1:0] a,
                                                         input int unsigned b);
        logic [FIELD_WIDTH:0] sum;
        sum = {1'b0, a} + b[FIELD_WIDTH:0];
        return sum[FIELD_WIDTH] ? FIELD_MAX : sum[FIELD_WIDTH-1:0];
    endfunction

    // encode one accepted code point, advance the string state and,
    // when keep is set, queue the bytes it should produce
    task automatic encode_code_point(input logic [31:0] cp, input logic eos, input bit keep);
        logic [7:0]           seq [4];
        int unsigned          len;
        logic                 fits;
        logic [FIELD_WIDTH:0] wide_end;
        result_t              r;
        // skipping the tail of a failed string: nothing comes out
        if (skipping) begin
            if (eos) begin
                skipping   = 1'b0;
                byte_count = '0;
            end
            return;
        end
        // oversized code point: one error result
        if (cp >= CP_LIMIT4) begin
            r.out_byte    = 8'h00;
            r.byte_offset = byte_count;
            r.byte_stored = 1'b0;
            r.run_last    = 1'b1;
            r.string_done = 1'b1;
            r.status      = ST_TOO_LARGE;
            r.total_size  = byte_count;
            if (keep)
                pending_bytes.push_back(r);
            if (eos)
                byte_count = '0;
            else
                skipping = 1'b1;
            return;
        end
        seq[1] = 8'h00;
        seq[2] = 8'h00;
        seq[3] = 8'h00;
        if (cp < CP_LIMIT1) begin
            len    = 1;
            seq[0] = cp[7:0];
        end else if (cp < CP_LIMIT2) begin
            len    = 2;
            seq[0] = LEAD2 | {3'b000, cp[10:6]};
            seq[1] = CONT | {2'b00, cp[5:0]};
        end else if (cp < CP_LIMIT3) begin
            len    = 3;
            seq[0] = LEAD3 | {4'b0000, cp[15:12]};
            seq[1] = CONT | {2'b00, cp[11:6]};
            seq[2] = CONT | {2'b00, cp[5:0]};
        end else begin
            len    = 4;
            seq[0] = LEAD4 | {5'b00000, cp[20:18]};
            seq[1] = CONT | {2'b00, cp[17:12]};
            seq[2] = CONT | {2'b00, cp[11:6]};
            seq[3] = CONT | {2'b00, cp[5:0]};
        end
        // whole sequence must fit to be stored
        wide_end = {1'b0, byte_count} + len[FIELD_WIDTH:0];
        fits     = wen_model && (wide_end <= {1'b0, cap_model});
        for (int k = 0; k < len; k++) begin
            r.out_byte    = seq[k];
            r.byte_offset = count_plus(byte_count, k);
            r.byte_stored = fits;
            r.run_last    = (k == len - 1) && !(eos && wen_model);
            r.string_done = (k == len - 1) && eos && !wen_model;
            r.status      = ST_OK;
            r.total_size  = count_plus(byte_count, k + 1);
            if (keep)
                pending_bytes.push_back(r);
        end
        byte_count = count_plus(byte_count, len);
        if (eos) begin
            // terminator, or capacity error when the buffer is full
            if (wen_model) begin
                r.out_byte    = 8'h00;
                r.byte_offset = byte_count;
                r.run_last    = 1'b1;
                r.string_done = 1'b1;
                r.total_size  = byte_count;
                if (byte_count >= cap_model) begin
                    r.byte_stored = 1'b0;
                    r.status      = ST_TOO_SMALL;
                end else begin
                    r.byte_stored = 1'b1;
                    r.status      = ST_OK;
                end
                if (keep)
                    pending_bytes.push_back(r);
            end
            byte_count = '0;
            skipping   = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // request and result checking, sampled at the rising edge
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            // predict first so a same-edge result would still find its entry
            if (s_tvalid && s_tready) begin
                encode_code_point(s_tdata, s_tlast, !side_typed);
                if (side_typed)
                    pending_bytes.push_back(side_want);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_bytes.size() == 0) begin
                    $error("result with nothing expected: tdata 0x%0h tuser 0x%0h",
                           m_tdata, m_tuser);
                    error_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    check_field("out_byte",    want.out_byte,    m_tdata[7:0]);
                    check_field("byte_offset", want.byte_offset, m_tdata[27:8]);
                    check_field("total_size",  want.total_size,  m_tdata[47:28]);
                    check_field("run_last",    want.run_last,    m_tlast);
                    check_field("byte_stored", want.byte_stored, m_tuser[0]);
                    check_field("string_done", want.string_done, m_tuser[1]);
                    check_field("status",      want.status,      m_tuser[3:2]);
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when the stimulus asks for one
    always @(posedge aclk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    // block goes idle: nothing offered, every expected result in, then the pipe drains
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write with read-back, only while idle
    task automatic write_register(input reg_index_t idx, input logic [31:0] value);
        logic [31:0] want_rd;
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // register takes the value at this edge
        case (idx)
            REG_CAPACITY: begin
                cap_model = value[FIELD_WIDTH-1:0];
                want_rd   = {12'h000, value[FIELD_WIDTH-1:0]};
            end
            default: begin
                wen_model = value[0];
                want_rd   = {31'h0, value[0]};
            end
        endcase
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("prdata", want_rd, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // offer one request and wait for it to be taken, then maybe go idle
    task automatic send_request(input logic [31:0] cp, input logic eos, input bit typed,
                                input result_t want);
        s_tvalid   <= 1'b1;
        s_tdata    <= cp;
        s_tlast    <= eos;
        side_typed <= typed;
        side_want  <= want;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (eos)
            strings_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // directed table builders
    task automatic add_item(input logic [31:0] cp, input logic eos);
        stim_row_t row;
        row.kind    = ROW_ITEM;
        row.value   = cp;
        row.eos     = eos;
        row.reg_sel = REG_CAPACITY;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input logic [31:0] cp, input logic eos, input logic [7:0] ob,
                             input logic [FIELD_WIDTH-1:0] off, input logic stored,
                             input logic last, input logic done, input status_t st,
                             input logic [FIELD_WIDTH-1:0] total);
        stim_row_t row;
        row.kind             = ROW_ITEM;
        row.value            = cp;
        row.eos              = eos;
        row.reg_sel          = REG_CAPACITY;
        row.typed            = 1'b1;
        row.want.out_byte    = ob;
        row.want.byte_offset = off;
        row.want.byte_stored = stored;
        row.want.run_last    = last;
        row.want.string_done = done;
        row.want.status      = st;
        row.want.total_size  = total;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input reg_index_t idx, input logic [31:0] value);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.value   = value;
        row.eos     = 1'b0;
        row.reg_sel = idx;
        row.typed   = 1'b0;
        row.want    = '0;
        directed_rows.push_back(row);
    endtask

    // random code point: mostly valid classes, some boundaries, some oversized
    function automatic logic [31:0] pick_code_point();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < 22)
            return $urandom_range(32'h7F, 32'h0);
        if (sel < 42)
            return $urandom_range(32'h7FF, 32'h80);
        if (sel < 62)
            return $urandom_range(32'hFFFF, 32'h800);
        if (sel < 82)
            return $urandom_range(32'h1F_FFFF, 32'h1_0000);
        if (sel < 93) begin
            case ($urandom_range(9))
                0: v = 32'h0;
                1: v = CP_LIMIT1 - 1;
                2: v = CP_LIMIT1;
                3: v = CP_LIMIT2 - 1;
                4: v = CP_LIMIT2;
                5: v = CP_LIMIT3 - 1;
                6: v = CP_LIMIT3;
                7: v = CP_LIMIT4 - 1;
                8: v = CP_LIMIT4;
                default: v = 32'hFFFF_FFFF;
            endcase
            return v;
        end
        // oversized, with the upper bits spread
        v = $urandom;
        if (v < CP_LIMIT4)
            v = v | (CP_LIMIT4 << $urandom_range(10));
        return v;
    endfunction

    // stimulus
    initial begin
        result_t     no_want;
        logic [31:0] cp;
        logic        eos;
        int unsigned len;
        int unsigned phase_count;
        no_want = '0;

        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tlast    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        side_typed <= 1'b0;
        side_want  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: capacity 0, writing enabled
        add_typed(32'h41, 1'b0, 8'h41, 20'd0, 1'b0, 1'b1, 1'b0, ST_OK, 20'd1);
        // oversized mid-string, then the tail is skipped up to end of string
        add_typed(32'h20_0000, 1'b0, 8'h00, 20'd1, 1'b0, 1'b1, 1'b1, ST_TOO_LARGE, 20'd1);
        add_item(32'h7F, 1'b0);
        add_item(32'h0, 1'b1);
        // capacity 0: byte not stored, terminator gives buffer too small
        add_item(32'h0, 1'b1);
        add_typed(32'hFFFF_FFFF, 1'b1, 8'h00, 20'd0, 1'b0, 1'b1, 1'b1, ST_TOO_LARGE, 20'd0);
        // class boundaries against a small buffer
        add_cfg(REG_CAPACITY, 32'd16);
        add_item(32'h7F, 1'b0);
        add_item(32'h80, 1'b0);
        add_item(32'h7FF, 1'b0);
        add_item(32'h800, 1'b0);
        add_item(32'hFFFF, 1'b0);
        add_item(32'h1_0000, 1'b0);
        add_item(32'h1F_FFFF, 1'b0);
        add_item(32'h0, 1'b1);
        // short string that fits, stored terminator
        add_item(32'h24, 1'b1);
        // oversized on the end-of-string item: no skipping afterwards
        add_item(32'h20AC, 1'b0);
        add_typed(32'h20_0000, 1'b1, 8'h00, 20'd3, 1'b0, 1'b1, 1'b1, ST_TOO_LARGE, 20'd3);
        // size counting only: done on the last byte
        add_cfg(REG_WRITE_EN, 32'd0);
        add_item(32'h1_0348, 1'b0);
        add_item(32'hE9, 1'b1);
        add_typed(32'h3F_FFFF, 1'b0, 8'h00, 20'd0, 1'b0, 1'b1, 1'b1, ST_TOO_LARGE, 20'd0);
        add_item(32'h41, 1'b1);
        // largest capacity
        add_cfg(REG_CAPACITY, {12'h000, FIELD_MAX});
        add_cfg(REG_WRITE_EN, 32'd1);
        add_item(32'h61, 1'b1);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_register(directed_rows[i].reg_sel, directed_rows[i].value);
            else
                send_request(directed_rows[i].value, directed_rows[i].eos,
                             directed_rows[i].typed, directed_rows[i].want);
        end

        // random strings, one idle pattern per phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_CAPACITY, $urandom_range(24));
                    write_register(REG_WRITE_EN, 32'd1);
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1: begin
                    write_register(REG_CAPACITY, {12'h000, FIELD_MAX});
                    send_idle_pct = 79;
                    stall_pct    <= 0;
                end
                2: begin
                    write_register(REG_CAPACITY, $urandom_range(40));
                    write_register(REG_WRITE_EN, 32'd0);
                    send_idle_pct = 0;
                    stall_pct    <= 79;
                end
                default: begin
                    write_register(REG_CAPACITY, $urandom_range(12));
                    write_register(REG_WRITE_EN, 32'd1);
                    send_idle_pct = 31;
                    stall_pct    <= 31;
                end
            endcase
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                len = $urandom_range(8, 1);
                for (int k = 0; k < len; k++) begin
                    cp  = pick_code_point();
                    eos = (k == len - 1);
                    // a few broken strings: stray or missing end of string
                    if ($urandom_range(99) < 4)
                        eos = ~eos;
                    // long receiver hold-off while the sender keeps offering
                    if (phase == 0 && phase_count == 15)
                        hold_tgl = ~hold_tgl;
                    // sender pause until every result is back
                    if (phase == 1 && phase_count == 25) begin
                        s_tvalid <= 1'b0;
                        do @(posedge aclk); while (pending_bytes.size() != 0);
                    end
                    send_request(cp, eos, 1'b0, no_want);
                    phase_count++;
                end
            end
        end

        // end of run: close any open string, then drain
        send_request(32'h0, 1'b1, 1'b0, no_want);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_bytes.size() != 0) begin
            $error("%0d expected results never arrived", pending_bytes.size());
            error_count++;
        end

        $display("covered %0d requests in %0d strings, %0d results checked, %0d register writes",
                 requests_sent, strings_sent, results_seen, reg_writes);
        $display("idle patterns: none, sender 79%%, receiver 79%%, both 31%%, plus one long hold-off");
        if (error_count == 0)
            $display("PASS code_point_to_utf8_encoder");
        else
            $display("FAIL code_point_to_utf8_encoder");
        $finish;
    end

endmodule
